[sv/bpks_pkg.sv]
// ----------------------------------------------------------------------------
// bpks_pkg: shared types and constants for the bit-program keystream stepper
// Sizes of the program store, LCG constants and sequencer state codes.
// ----------------------------------------------------------------------------
package bpks_pkg;

  // program store size and derived widths
  localparam int unsigned MAX_PROGRAM_BITS = 4096;
  localparam int unsigned POS_W            = $clog2(MAX_PROGRAM_BITS);
  localparam int unsigned LEN_W            = POS_W + 1;
  localparam int unsigned JUMP_W           = 64;
  localparam int unsigned JBIT_W           = $clog2(JUMP_W);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PROGRAM_BITS);

  // LCG: state = state * LCG_MUL + LCG_ADD, flip when above FLIP_LIMIT
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] FLIP_LIMIT = 32'h8000_0000;

  // read slots of one step, in order
  localparam logic [1:0] RD_SKIP = 2'd0;
  localparam logic [1:0] RD_EMIT = 2'd1;
  localparam logic [1:0] RD_INCR = 2'd2;
  localparam logic [1:0] RD_DIR  = 2'd3;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_RD   = 7'b000_0010,
    S_WR   = 7'b000_0100,
    S_DIV  = 7'b000_1000,
    S_RED  = 7'b001_0000,
    S_ADV  = 7'b010_0000,
    S_EMIT = 7'b100_0000
  } state_t;

endpackage

[sv/bit_program_keystream_step.sv]
// ----------------------------------------------------------------------------
// bit_program_keystream_step: keystream stepper driven by a bit program
// Loads program bits, then walks the program once per data bit and emits
// a key bit for every step whose skip bit reads as zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries load and step transactions.
//   A load transaction (in_kind = 0) writes one program bit. A step
//   transaction (in_kind = 1) keeps the block busy from accept until it is
//   free again and, when program_length was cut below the current position,
//   also reduces that position modulo the length. The iterative remainder of
//   the 64-bit jump by the program length, one bit per cycle through a single
//   compare-subtract unit, takes most of that time; four read-modify-writes of
//   the bit store add the rest. in_stall is high while a step is in progress.
//   Output channel (out_valid / out_stall) carries key_bit; a step with skip
//   set produces no transaction. A result waits in the output register; a
//   step that finishes while it still waits holds until the receiver takes it.
//   The APB port holds program_length at address 0; write it only while idle.
//   Reset (rst_n low, synchronous) clears position, LCG, counter and the
//   channels and sets program_length to 4096. The program store is not
//   cleared: load every bit that a step may read.
// ----------------------------------------------------------------------------
module bit_program_keystream_step
  import bpks_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [POS_W-1:0] in_bit_index,
  input  logic             in_load_value,
  input  logic             in_data_bit,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_key_bit,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state_r,    state_nxt;
  logic [JBIT_W-1:0]   bit_cnt_r,  bit_cnt_nxt;
  logic [1:0]          rd_cnt_r,   rd_cnt_nxt;
  logic [JUMP_W-1:0]   jump_r,     jump_nxt;
  logic [POS_W-1:0]    rem_r,      rem_nxt;
  logic [POS_W-1:0]    jmod_r,     jmod_nxt;
  logic [POS_W-1:0]    pos_r,      pos_nxt;
  logic [31:0]         lcg_r,      lcg_nxt;
  logic [JUMP_W-1:0]   ctr_r,      ctr_nxt;
  logic                data_r,     data_nxt;
  logic                skip_r,     skip_nxt;
  logic                emit_r,     emit_nxt;
  logic                incr_r,     incr_nxt;
  logic [LEN_W-1:0]    len_cfg_r,  len_cfg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                key_bit_r,  key_bit_nxt;

  // program store
  logic                prog_mem [MAX_PROGRAM_BITS];
  logic                rd_data_r;
  logic                mem_we;
  logic [POS_W-1:0]    mem_addr;
  logic                mem_wd;

  // --------------------------------------------------------------------------
  // Effective length and shared compare-subtract unit
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]    len_eff;
  logic [LEN_W-1:0]    cs_in;
  logic [LEN_W-1:0]    cs_out;
  logic                flip;
  logic                cur_x;
  logic                in_acc;
  logic                cfg_wr;

  // clamp the length register to 1..MAX_PROGRAM_BITS
  always_comb begin
    if (len_cfg_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_cfg_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_cfg_r;
    end
  end

  // select the unit's operand: a remainder step or a position advance
  always_comb begin
    unique case (state_r)
      S_DIV:   cs_in = {rem_r, jump_r[bit_cnt_r]};
      S_RED:   cs_in = {rem_r, pos_r[bit_cnt_r[$clog2(POS_W)-1:0]]};
      default: cs_in = {1'b0, pos_r} + {1'b0, jmod_r};
    endcase
  end

  assign cs_out = (cs_in >= len_eff) ? (cs_in - len_eff) : cs_in;

  // flip decision uses the LCG value updated in the read cycle
  assign flip  = (lcg_r > FLIP_LIMIT);
  assign cur_x = rd_data_r ^ data_r;

  assign in_acc = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    jump_nxt      = jump_r;
    rem_nxt       = rem_r;
    jmod_nxt      = jmod_r;
    pos_nxt       = pos_r;
    lcg_nxt       = lcg_r;
    ctr_nxt       = ctr_r;
    data_nxt      = data_r;
    skip_nxt      = skip_r;
    emit_nxt      = emit_r;
    incr_nxt      = incr_r;
    key_bit_nxt   = key_bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    len_cfg_nxt   = len_cfg_r;
    mem_we        = 1'b0;
    mem_addr      = pos_r;
    mem_wd        = rd_data_r ^ flip;

    // take a register write
    if (cfg_wr && (paddr[2] == 1'b0)) begin
      len_cfg_nxt = pwdata[LEN_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_LOAD) begin
            mem_we   = 1'b1;
            mem_addr = in_bit_index;
            mem_wd   = in_load_value;
          end else begin
            data_nxt   = in_data_bit;
            jump_nxt   = (ctr_r + JUMP_W'(1)) << in_data_bit;
            rd_cnt_nxt = RD_SKIP;
            state_nxt  = S_RD;
          end
        end
      end
      // read issued at pos_r; advance the LCG alongside
      S_RD: begin
        lcg_nxt   = lcg_r * LCG_MUL + LCG_ADD;
        state_nxt = S_WR;
      end
      // write back the possibly flipped bit and record the read
      S_WR: begin
        mem_we = 1'b1;
        unique case (rd_cnt_r)
          RD_SKIP: skip_nxt = cur_x;
          RD_EMIT: emit_nxt = cur_x;
          RD_INCR: incr_nxt = cur_x;
          RD_DIR:  ;
          default: ;
        endcase
        if (rd_cnt_r == RD_SKIP) begin
          rem_nxt     = '0;
          bit_cnt_nxt = JBIT_W'(JUMP_W - 1);
          state_nxt   = S_DIV;
        end else begin
          state_nxt   = S_ADV;
        end
      end
      // one remainder bit of jump per cycle
      S_DIV: begin
        rem_nxt     = cs_out[POS_W-1:0];
        bit_cnt_nxt = bit_cnt_r - JBIT_W'(1);
        if (bit_cnt_r == '0) begin
          jmod_nxt = cs_out[POS_W-1:0];
          if ({1'b0, pos_r} >= len_eff) begin
            rem_nxt     = '0;
            bit_cnt_nxt = JBIT_W'(POS_W - 1);
            state_nxt   = S_RED;
          end else begin
            state_nxt   = S_ADV;
          end
        end
      end
      // reduce a position left beyond a shortened length
      S_RED: begin
        rem_nxt     = cs_out[POS_W-1:0];
        bit_cnt_nxt = bit_cnt_r - JBIT_W'(1);
        if (bit_cnt_r == '0) begin
          pos_nxt   = cs_out[POS_W-1:0];
          state_nxt = S_ADV;
        end
      end
      // advance position by jump modulo length
      S_ADV: begin
        pos_nxt = cs_out[POS_W-1:0];
        if (rd_cnt_r == RD_DIR) begin
          ctr_nxt   = ctr_r + JUMP_W'(incr_r);
          state_nxt = S_EMIT;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 2'd1;
          state_nxt  = S_RD;
        end
      end
      // hand the key bit to the output register once it is free
      S_EMIT: begin
        if (skip_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          key_bit_nxt   = emit_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // State and payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      lcg_r       <= '0;
      ctr_r       <= '0;
      len_cfg_r   <= LEN_MAX;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= RD_SKIP;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      lcg_r       <= lcg_nxt;
      ctr_r       <= ctr_nxt;
      len_cfg_r   <= len_cfg_nxt;
      out_valid_r <= out_valid_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jump_r    <= jump_nxt;
    rem_r     <= rem_nxt;
    jmod_r    <= jmod_nxt;
    data_r    <= data_nxt;
    skip_r    <= skip_nxt;
    emit_r    <= emit_nxt;
    incr_r    <= incr_nxt;
    key_bit_r <= key_bit_nxt;
  end

  // program store: one write, one registered read
  always_ff @(posedge clk) begin
    rd_data_r <= prog_mem[pos_r];
    if (mem_we) begin
      prog_mem[mem_addr] <= mem_wd;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_key_bit = key_bit_r;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == 1'b0) ? {{(32 - LEN_W){1'b0}}, len_cfg_r} : '0;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside the emit state");

  a_ctr_at_last_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(ctr_r)) |-> $past(state_r == S_ADV && rd_cnt_r == RD_DIR))
    else $error("step counter changed outside the final advance");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV) |=> ({1'b0, pos_r} < len_eff))
    else $error("position not below length after advance");

  a_jmod_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && bit_cnt_r == '0) |=> ({1'b0, jmod_r} < len_eff))
    else $error("jump remainder not below length");

endmodule
